// ===== design/sas_pkg.sv =====
package sas_pkg;

    // default ring depth, top level can override
    localparam int unsigned WINDOW_MAX_DEFAULT = 4096;

    // configuration port
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_HOP_SIZE      = 2'd1,
        REG_THRESHOLD     = 2'd2,
        REG_MIN_SAMPLES   = 2'd3
    } sas_reg_t;

    localparam logic [12:0] WINDOW_LENGTH_RESET = 13'd2048;
    localparam logic [15:0] HOP_SIZE_RESET      = 16'd512;
    localparam logic [15:0] THRESHOLD_RESET     = 16'd1000;
    localparam logic [31:0] MIN_SAMPLES_RESET   = 32'd88200;
    localparam logic [28:0] LIMIT_RESET         = 29'(1000 * 2048);

    // result queue
    localparam int unsigned OUTQ_DEPTH  = 8;
    localparam int unsigned OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_ALMOST = OUTQ_DEPTH - 4;

    typedef struct packed {
        logic [12:0] window;       // effective window, 1..WINDOW_MAX
        logic [15:0] hop;          // effective hop, never zero
        logic [28:0] limit;        // threshold * window
        logic [31:0] min_samples;
        logic        restart;      // window length written this cycle
    } sas_cfg_t;

    typedef struct packed {
        logic [31:0] position;
        logic        end_of_list;
    } sas_result_t;

    typedef struct packed {
        logic        push0;
        logic        push1;
        sas_result_t item0;
        sas_result_t item1;
    } sas_push_t;

endpackage

// ===== design/sas_ram.sv =====
module sas_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = sas_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read during write to the same address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sas_cfg.sv =====
module sas_cfg #(
    parameter int unsigned WINDOW_MAX = sas_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sas_pkg::PADDR_W-1:0]   paddr,
    input  logic [sas_pkg::PDATA_W-1:0]   pwdata,
    output logic [sas_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output sas_pkg::sas_cfg_t             cfg
);

    logic [12:0] window_length_reg;
    logic [15:0] hop_size_reg;
    logic [15:0] threshold_reg;
    logic [31:0] min_samples_reg;
    logic [28:0] limit_reg;
    logic [28:0] limit_next;

    logic             wr_en;
    sas_pkg::sas_reg_t reg_sel;
    logic [12:0]      window_eff;
    logic [15:0]      hop_eff;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = sas_pkg::sas_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= sas_pkg::WINDOW_LENGTH_RESET;
            hop_size_reg      <= sas_pkg::HOP_SIZE_RESET;
            threshold_reg     <= sas_pkg::THRESHOLD_RESET;
            min_samples_reg   <= sas_pkg::MIN_SAMPLES_RESET;
            limit_reg         <= sas_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
            if (wr_en)
            begin
                unique case (reg_sel)
                    sas_pkg::REG_WINDOW_LENGTH: window_length_reg <= pwdata[12:0];
                    sas_pkg::REG_HOP_SIZE:      hop_size_reg      <= pwdata[15:0];
                    sas_pkg::REG_THRESHOLD:     threshold_reg     <= pwdata[15:0];
                    sas_pkg::REG_MIN_SAMPLES:   min_samples_reg   <= pwdata;
                    default:                    ;
                endcase
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            sas_pkg::REG_WINDOW_LENGTH: prdata = 32'(window_length_reg);
            sas_pkg::REG_HOP_SIZE:      prdata = 32'(hop_size_reg);
            sas_pkg::REG_THRESHOLD:     prdata = 32'(threshold_reg);
            sas_pkg::REG_MIN_SAMPLES:   prdata = min_samples_reg;
            default:                    prdata = '0;
        endcase
    end

    // clamp window to 1..WINDOW_MAX, hop of zero acts as one
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            window_eff = 13'd1;
        end
        else if (32'(window_length_reg) > 32'(WINDOW_MAX))
        begin
            window_eff = 13'(WINDOW_MAX);
        end
        else
        begin
            window_eff = window_length_reg;
        end
        hop_eff = (hop_size_reg == '0) ? 16'd1 : hop_size_reg;
    end

    // silence limit registered, only used in the cycle after an item enters
    assign limit_next = 29'(threshold_reg) * 29'(window_eff);

    assign cfg.window      = window_eff;
    assign cfg.hop         = hop_eff;
    assign cfg.limit       = limit_reg;
    assign cfg.min_samples = min_samples_reg;
    assign cfg.restart     = wr_en && (reg_sel == sas_pkg::REG_WINDOW_LENGTH);

endmodule

// ===== design/sas_engine.sv =====
module sas_engine #(
    parameter int unsigned WINDOW_MAX = sas_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sas_pkg::sas_cfg_t        cfg,
    input  logic                     accept,
    input  logic signed [15:0]       sample,
    input  logic                     is_last,
    output sas_pkg::sas_push_t       push
);

    localparam int unsigned AW = $clog2(WINDOW_MAX);

    // stage 1: ring write and read of the sample leaving the window
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [AW-1:0] raddr;
    logic [31:0]   wp32;
    logic [31:0]   w32;
    logic [31:0]   back;

    // stage 2: window test and running sum
    logic               s2_valid_reg;
    logic signed [15:0] s2_sample_reg;
    logic               s2_last_reg;
    logic signed [15:0] old_sample;

    logic signed [28:0] sum_reg;
    logic signed [28:0] sum_next;
    logic [31:0]        idx_reg;
    logic [31:0]        idx_next;
    logic [15:0]        phase_reg;
    logic [15:0]        phase_next;
    logic [31:0]        seg_reg;
    logic [31:0]        seg_next;
    logic               loud_reg;
    logic               loud_next;

    logic               full;
    logic               test;
    logic [28:0]        mag;
    logic               loud;
    logic               emit_slice;
    logic [31:0]        seg_base;
    logic [32:0]        seg_sum;
    logic [16:0]        phase_inc;
    logic [31:0]        slice_pos;
    logic               first;
    sas_pkg::sas_result_t last_item;

    assign wp32 = 32'(wp_reg);
    assign w32  = 32'(cfg.window);
    assign back = (wp32 >= w32) ? (wp32 - w32) : (wp32 + 32'(WINDOW_MAX) - w32);
    assign raddr = back[AW-1:0];
    assign wp_next = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;

    sas_ram #(
        .WIDTH(16),
        .DEPTH(WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (sample),
        .re    (accept),
        .raddr (raddr),
        .rdata (old_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= accept;
            if (cfg.restart)
            begin
                wp_reg <= '0;
            end
            else if (accept)
            begin
                wp_reg <= is_last ? '0 : wp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_sample_reg <= sample;
            s2_last_reg   <= is_last;
        end
    end

    always_comb
    begin
        full       = idx_reg >= w32;
        test       = full && (phase_reg == '0);
        mag        = sum_reg[28] ? 29'(-sum_reg) : 29'(sum_reg);
        loud       = !(mag < cfg.limit);
        emit_slice = test && (loud != loud_reg) && (seg_reg > cfg.min_samples);
        seg_base   = emit_slice ? '0 : seg_reg;
        seg_sum    = {1'b0, seg_base} + 33'(cfg.hop);
        phase_inc  = {1'b0, phase_reg} + 17'd1;
        slice_pos  = idx_reg - w32 + 32'(cfg.window[12:1]);
        first      = (idx_reg == '0);

        loud_next  = (test && (loud != loud_reg)) ? loud : loud_reg;
        seg_next   = test ? (seg_sum[32] ? '1 : seg_sum[31:0]) : seg_reg;
        phase_next = phase_reg;
        if (full)
        begin
            phase_next = (phase_inc >= {1'b0, cfg.hop}) ? '0 : phase_inc[15:0];
        end
        sum_next = sum_reg + {{13{s2_sample_reg[15]}}, s2_sample_reg}
                 - (full ? {{13{old_sample[15]}}, old_sample} : 29'sd0);
        idx_next = (idx_reg == '1) ? idx_reg : idx_reg + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            idx_reg   <= '0;
            phase_reg <= '0;
            seg_reg   <= '0;
            loud_reg  <= 1'b1;
        end
        else if (cfg.restart || (s2_valid_reg && s2_last_reg))
        begin
            sum_reg   <= '0;
            idx_reg   <= '0;
            phase_reg <= '0;
            seg_reg   <= '0;
            loud_reg  <= 1'b1;
        end
        else if (s2_valid_reg)
        begin
            sum_reg   <= sum_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            seg_reg   <= seg_next;
            loud_reg  <= loud_next;
        end
    end

    // order within one item: clip start, slice point, clip length
    always_comb
    begin
        last_item.position    = idx_next;
        last_item.end_of_list = 1'b1;

        push.push0 = s2_valid_reg && (first || emit_slice || s2_last_reg);
        push.push1 = s2_valid_reg && (first || emit_slice) && s2_last_reg;
        push.item1 = last_item;
        if (first)
        begin
            push.item0.position    = '0;
            push.item0.end_of_list = 1'b0;
        end
        else if (emit_slice)
        begin
            push.item0.position    = slice_pos;
            push.item0.end_of_list = 1'b0;
        end
        else
        begin
            push.item0 = last_item;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) push.push1 |-> push.push0)
        else $error("second result pushed without a first");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |=> (idx_reg == '0 && sum_reg == '0))
        else $error("clip state not cleared after last item");
    assert property (@(posedge clk) disable iff (!rst_n) cfg.restart |=> wp_reg == '0)
        else $error("ring pointer not cleared on window change");
`endif

endmodule

// ===== design/sas_outq.sv =====
module sas_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sas_pkg::sas_push_t    push,
    output logic                  almost_full,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [31:0]           position,
    output logic                  end_of_list
);

    localparam int unsigned PW = sas_pkg::OUTQ_PTR_W;

    sas_pkg::sas_result_t mem [sas_pkg::OUTQ_DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [PW:0]   count_reg;
    logic [PW-1:0] wr_next;
    logic [PW:0]   count_next;
    logic          pop;
    sas_pkg::sas_result_t head;

    assign head         = mem[rd_reg];
    assign result_valid = (count_reg != '0);
    assign position     = head.position;
    assign end_of_list  = head.end_of_list;
    assign pop          = result_valid && !result_stall;
    assign almost_full  = (count_reg > (PW + 1)'(sas_pkg::OUTQ_ALMOST));

    assign wr_next    = wr_reg + PW'(push.push0) + PW'(push.push1);
    assign count_next = count_reg + (PW + 1)'(push.push0) + (PW + 1)'(push.push1)
                      - (PW + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wr_reg] <= push.item0;
        end
        if (push.push1)
        begin
            mem[wr_reg + 1'b1] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_reg + PW'(pop);
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW + 1)'(sas_pkg::OUTQ_DEPTH))
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_reg - rd_reg) == count_reg[PW-1:0])
        else $error("result queue pointers disagree with count");
`endif

endmodule

// ===== design/silence_audio_slicer.sv =====
// silence based audio slicer
// sample channel: one signed 16-bit pcm sample per item (sample, is_last), taken
// when sample_valid is high and sample_stall is low. is_last closes the clip.
// result channel: slice points (position, end_of_list) under result_valid and
// result_stall; the first sample of a clip gives position 0, the last sample gives
// the clip length with end_of_list set.
// apb port: window_length at 0x0, hop_size at 0x4, threshold at 0x8,
// min_samples at 0xc; write only while the block is idle. writing
// window_length restarts the clip.
// throughput: one sample per clock while sample_stall is low. the ring buffer
// memory is written and read once per sample, the running sum and window test run
// in the following cycle. results are pushed from the stage 2 registers into the
// results queue and leave from its head.
// a results queue of eight entries holds items while result_stall is high;
// sample_stall rises once more than four entries are waiting.
// reset clears the clip state and the queue and loads the register defaults;
// the ring memory is not cleared and needs no clearing pass.
module silence_audio_slicer #(
    parameter int unsigned WINDOW_MAX = sas_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sas_pkg::PADDR_W-1:0]  paddr,
    input  logic [sas_pkg::PDATA_W-1:0]  pwdata,
    output logic [sas_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic signed [15:0]           sample,
    input  logic                         is_last,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [31:0]                  position,
    output logic                         end_of_list
);

    sas_pkg::sas_cfg_t  cfg;
    sas_pkg::sas_push_t push;
    logic               almost_full;
    logic               accept;

    assign sample_stall = almost_full;
    assign accept       = sample_valid && !almost_full;

    sas_cfg #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sas_engine #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .sample  (sample),
        .is_last (is_last),
        .push    (push)
    );

    sas_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .almost_full  (almost_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .position     (position),
        .end_of_list  (end_of_list)
    );

endmodule
